/* rtl/core/pcd_pkg.sv */
// Shared widths, operation codes, register indexes and result kinds for the
// path pair conflict detector. No dependencies.
package pcd_pkg;

  localparam int OP_W       = 2;
  localparam int STEP_W     = 8;
  localparam int LEN_W      = 9;
  localparam int AGENT_W    = 10;
  localparam int KIND_W     = 2;
  localparam int WIN_W      = 8;
  localparam int ROB_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROBUST = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd2;

endpackage

/* rtl/core/path_pair_conflict_detector_core.sv */
// Top level of the path pair conflict detector: path stores, sequencer and
// the compare logic. Depends on pcd_pkg.
//
//   channel   direction  handshake               transfer condition
//   item      in         start / busy            start high and busy low
//   result    out        done_o (one cycle)      every cycle done_o is high
//   config    in         cfg_we_i                every cycle cfg_we_i is high
//
// A load item writes its store entry at the accepting edge. A check passes
// the setup state, then the same-step scan over the steps from first_time_i
// and, in hold mode with unequal lengths, the parked-end tail over the
// remaining steps of the longer path; in robust mode each step of path A is
// compared in turn with each path B entry inside its time margin, since one
// read port per store feeds the comparison. The result shows in the cycle
// after the last compare. Reset clears the control state and the registers
// to their reset values; the stores keep no reset. The receiver cannot
// stall, and busy stays high until the result is shown.
module path_pair_conflict_detector_core #(
  parameter int MAX_STEPS     = 256,
  parameter int LOCATION_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [pcd_pkg::OP_W-1:0]       opcode_i,
  input  logic [pcd_pkg::STEP_W-1:0]     step_index_i,
  input  logic [LOCATION_BITS-1:0]       cell_location_i,
  input  logic [pcd_pkg::STEP_W-1:0]     first_time_i,
  input  logic [pcd_pkg::LEN_W-1:0]      length_a_i,
  input  logic [pcd_pkg::LEN_W-1:0]      length_b_i,
  input  logic [pcd_pkg::AGENT_W-1:0]    agent_a_i,
  input  logic [pcd_pkg::AGENT_W-1:0]    agent_b_i,
  input  logic                           cfg_we_i,
  input  logic [pcd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           done_o,
  output logic [pcd_pkg::KIND_W-1:0]     conflict_kind_o,
  output logic [pcd_pkg::AGENT_W-1:0]    agent_first_o,
  output logic [pcd_pkg::AGENT_W-1:0]    agent_second_o,
  output logic [LOCATION_BITS-1:0]       place_first_o,
  output logic [LOCATION_BITS-1:0]       place_second_o,
  output logic [pcd_pkg::LEN_W-1:0]      conflict_time_o
);
  import pcd_pkg::*;

  localparam int AW = $clog2(MAX_STEPS);
  localparam int SW = 4;
  localparam int TW = LEN_W + 1;

  localparam logic [SW-1:0] S_IDLE   = 4'd0;
  localparam logic [SW-1:0] S_SETUP  = 4'd1;
  localparam logic [SW-1:0] S_PPRIME = 4'd2;
  localparam logic [SW-1:0] S_PLOAD  = 4'd3;
  localparam logic [SW-1:0] S_PMAIN  = 4'd4;
  localparam logic [SW-1:0] S_TPRIME = 4'd5;
  localparam logic [SW-1:0] S_TPARK  = 4'd6;
  localparam logic [SW-1:0] S_TSCAN  = 4'd7;
  localparam logic [SW-1:0] S_RPRIME = 4'd8;
  localparam logic [SW-1:0] S_RFIRST = 4'd9;
  localparam logic [SW-1:0] S_RSCAN  = 4'd10;

  logic [LOCATION_BITS-1:0] mem_a [MAX_STEPS];
  logic [LOCATION_BITS-1:0] mem_b [MAX_STEPS];

  logic                     hold_q;
  logic [WIN_W-1:0]         win_q;
  logic [ROB_W-1:0]         rob_q;

  logic [SW-1:0]            state_q, state_d;
  logic [LEN_W-1:0]         t_q, t_d;
  logic [LEN_W-1:0]         e_q, e_d;
  logic [LEN_W-1:0]         la_q, la_d;
  logic [LEN_W-1:0]         lb_q, lb_d;
  logic [LEN_W-1:0]         i_q, i_d;
  logic [LEN_W-1:0]         hi_q, hi_d;
  logic [AGENT_W-1:0]       ag_a_q, ag_a_d;
  logic [AGENT_W-1:0]       ag_b_q, ag_b_d;
  logic [LOCATION_BITS-1:0] cur_a_q, cur_a_d;
  logic [LOCATION_BITS-1:0] cur_b_q, cur_b_d;
  logic [LOCATION_BITS-1:0] loc_q, loc_d;
  logic [LOCATION_BITS-1:0] rd_a_q, rd_b_q;
  logic                     done_q;

  logic [KIND_W-1:0]        kind_q;
  logic [AGENT_W-1:0]       agf_q, ags_q;
  logic [LOCATION_BITS-1:0] pf_q, ps_q;
  logic [LEN_W-1:0]         time_q;

  logic                     fin;
  logic [KIND_W-1:0]        res_kind;
  logic [AGENT_W-1:0]       res_agf, res_ags;
  logic [LOCATION_BITS-1:0] res_pf, res_ps;
  logic [LEN_W-1:0]         res_time;

  logic [AW-1:0]            addr_a, addr_b, waddr;
  logic                     step_ok, we_a, we_b;
  logic [LEN_W-1:0]         la_clamp, lb_clamp;
  logic [LEN_W-1:0]         win_len, ea, eb;
  logic [LEN_W-1:0]         t_inc, t_inc2;
  logic                     a_short;
  logic [LOCATION_BITS-1:0] long_rd, loc_w;
  logic [LEN_W-1:0]         long_len, lo;
  logic [TW-1:0]            tk, s2m1, s2k;

  assign busy    = (state_q != S_IDLE);
  assign step_ok = (32'(step_index_i) < MAX_STEPS);
  assign waddr   = AW'(step_index_i);
  assign we_a    = start && !busy && (opcode_i == OP_LOAD_A) && step_ok;
  assign we_b    = start && !busy && (opcode_i == OP_LOAD_B) && step_ok;

  assign la_clamp = (32'(length_a_i) > MAX_STEPS) ? LEN_W'(MAX_STEPS) : length_a_i;
  assign lb_clamp = (32'(length_b_i) > MAX_STEPS) ? LEN_W'(MAX_STEPS) : length_b_i;

  assign win_len = LEN_W'(win_q) + LEN_W'(1);
  assign ea      = (hold_q || la_q < win_len) ? la_q : win_len;
  assign eb      = (hold_q || lb_q < win_len) ? lb_q : win_len;
  assign t_inc   = t_q + LEN_W'(1);
  assign t_inc2  = t_q + LEN_W'(2);

  assign a_short  = (la_q < lb_q);
  assign long_rd  = a_short ? rd_b_q : rd_a_q;
  assign long_len = a_short ? lb_q : la_q;

  assign lo    = (t_q >= LEN_W'(rob_q)) ? t_q - LEN_W'(rob_q) : '0;
  assign tk    = TW'(t_q) + TW'(rob_q);
  assign s2m1  = TW'(lb_q) - TW'(1);
  assign s2k   = TW'(lb_q) + TW'(rob_q);
  assign loc_w = (state_q == S_RFIRST) ? rd_a_q : loc_q;

  always_comb begin
    state_d  = state_q;
    t_d      = t_q;
    e_d      = e_q;
    la_d     = la_q;
    lb_d     = lb_q;
    i_d      = i_q;
    hi_d     = hi_q;
    ag_a_d   = ag_a_q;
    ag_b_d   = ag_b_q;
    cur_a_d  = cur_a_q;
    cur_b_d  = cur_b_q;
    loc_d    = loc_q;
    addr_a   = AW'(t_q);
    addr_b   = AW'(t_q);
    fin      = 1'b0;
    res_kind = KIND_NONE;
    res_agf  = '0;
    res_ags  = '0;
    res_pf   = '0;
    res_ps   = '0;
    res_time = '0;
    case (state_q)
      S_IDLE: begin
        if (start && opcode_i == OP_CHECK) begin
          t_d     = LEN_W'(first_time_i);
          la_d    = la_clamp;
          lb_d    = lb_clamp;
          ag_a_d  = agent_a_i;
          ag_b_d  = agent_b_i;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        if (la_q == '0 || lb_q == '0) begin
          fin = 1'b1;
        end else begin
          la_d    = ea;
          lb_d    = eb;
          e_d     = (ea < eb) ? ea : eb;
          state_d = (hold_q || rob_q == '0) ? S_PPRIME : S_RPRIME;
        end
      end
      S_PPRIME: begin
        if (t_q < e_q) begin
          state_d = S_PLOAD;
        end else if (hold_q && la_q != lb_q) begin
          state_d = S_TPRIME;
        end else begin
          fin = 1'b1;
        end
      end
      S_PLOAD: begin
        cur_a_d = rd_a_q;
        cur_b_d = rd_b_q;
        addr_a  = AW'(t_inc);
        addr_b  = AW'(t_inc);
        state_d = S_PMAIN;
      end
      S_PMAIN: begin
        addr_a = AW'(t_inc2);
        addr_b = AW'(t_inc2);
        if (cur_a_q == cur_b_q) begin
          fin      = 1'b1;
          res_kind = KIND_VERTEX;
          res_agf  = ag_a_q;
          res_ags  = ag_b_q;
          res_pf   = cur_a_q;
          res_time = t_q;
        end else if (t_inc < e_q && cur_a_q == rd_b_q && cur_b_q == rd_a_q) begin
          fin      = 1'b1;
          res_kind = KIND_EDGE;
          res_agf  = ag_a_q;
          res_ags  = ag_b_q;
          res_pf   = cur_a_q;
          res_ps   = cur_b_q;
          res_time = t_inc;
        end else if (t_inc < e_q) begin
          t_d     = t_inc;
          cur_a_d = rd_a_q;
          cur_b_d = rd_b_q;
        end else if (hold_q && la_q != lb_q) begin
          state_d = S_TPRIME;
        end else begin
          fin = 1'b1;
        end
      end
      S_TPRIME: begin
        addr_a  = AW'(e_q - LEN_W'(1));
        addr_b  = AW'(e_q - LEN_W'(1));
        t_d     = e_q;
        state_d = S_TPARK;
      end
      S_TPARK: begin
        loc_d   = a_short ? rd_a_q : rd_b_q;
        state_d = S_TSCAN;
      end
      S_TSCAN: begin
        addr_a = AW'(t_inc);
        addr_b = AW'(t_inc);
        if (long_rd == loc_q) begin
          fin      = 1'b1;
          res_kind = KIND_VERTEX;
          res_agf  = a_short ? ag_a_q : ag_b_q;
          res_ags  = a_short ? ag_b_q : ag_a_q;
          res_pf   = loc_q;
          res_time = t_q;
        end else if (t_inc < long_len) begin
          t_d = t_inc;
        end else begin
          fin = 1'b1;
        end
      end
      S_RPRIME: begin
        addr_b = AW'(lo);
        if (t_q >= la_q || s2k <= TW'(t_q)) begin
          fin = 1'b1;
        end else begin
          i_d     = lo;
          hi_d    = (tk < s2m1) ? LEN_W'(tk) : LEN_W'(s2m1);
          state_d = S_RFIRST;
        end
      end
      S_RFIRST, S_RSCAN: begin
        loc_d  = loc_w;
        addr_b = AW'(i_q + LEN_W'(1));
        if (rd_b_q == loc_w) begin
          fin      = 1'b1;
          res_kind = KIND_VERTEX;
          res_agf  = ag_a_q;
          res_ags  = ag_b_q;
          res_pf   = loc_w;
          res_time = (i_q < t_q) ? i_q : t_q;
        end else if (i_q < hi_q) begin
          i_d     = i_q + LEN_W'(1);
          state_d = S_RSCAN;
        end else begin
          t_d     = t_inc;
          state_d = S_RPRIME;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[waddr] <= cell_location_i;
    end
    if (we_b) begin
      mem_b[waddr] <= cell_location_i;
    end
    rd_a_q <= mem_a[addr_a];
    rd_b_q <= mem_b[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      win_q  <= '1;
      rob_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HOLD:   hold_q <= cfg_data_i[0];
        CFG_WINDOW: win_q  <= cfg_data_i[WIN_W-1:0];
        CFG_ROBUST: rob_q  <= cfg_data_i[ROB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    e_q     <= e_d;
    la_q    <= la_d;
    lb_q    <= lb_d;
    i_q     <= i_d;
    hi_q    <= hi_d;
    ag_a_q  <= ag_a_d;
    ag_b_q  <= ag_b_d;
    cur_a_q <= cur_a_d;
    cur_b_q <= cur_b_d;
    loc_q   <= loc_d;
    if (fin) begin
      kind_q <= res_kind;
      agf_q  <= res_agf;
      ags_q  <= res_ags;
      pf_q   <= res_pf;
      ps_q   <= res_ps;
      time_q <= res_time;
    end
  end

  assign done_o          = done_q;
  assign conflict_kind_o = kind_q;
  assign agent_first_o   = agf_q;
  assign agent_second_o  = ags_q;
  assign place_first_o   = pf_q;
  assign place_second_o  = ps_q;
  assign conflict_time_o = time_q;

endmodule

/* rtl/core/pcd_checker.sv */
// Port-level checks for the path pair conflict detector, bound to the top
// level. Depends on pcd_pkg and path_pair_conflict_detector_core.
module pcd_checker #(
  parameter int LOCATION_BITS = 20
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic [pcd_pkg::OP_W-1:0]       opcode_i,
  input logic                           done_o,
  input logic [pcd_pkg::KIND_W-1:0]     conflict_kind_o,
  input logic [pcd_pkg::AGENT_W-1:0]    agent_first_o,
  input logic [pcd_pkg::AGENT_W-1:0]    agent_second_o,
  input logic [LOCATION_BITS-1:0]       place_first_o,
  input logic [LOCATION_BITS-1:0]       place_second_o,
  input logic [pcd_pkg::LEN_W-1:0]      conflict_time_o
);
  import pcd_pkg::*;

  // A check occupies the block, and a load finishes at its own transfer.
  a_check_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && opcode_i == OP_CHECK |=> busy)
    else $error("check transfer did not make the block busy");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (opcode_i == OP_LOAD_A || opcode_i == OP_LOAD_B) |=> !busy)
    else $error("load transfer made the block busy");

  // Every result closes a busy period and lasts exactly one cycle.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) && !busy)
    else $error("result shown without a finished check");

  a_result_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && conflict_kind_o != KIND_EDGE |->
      place_second_o == '0 &&
      (conflict_kind_o != KIND_NONE ||
       (agent_first_o == '0 && agent_second_o == '0 &&
        place_first_o == '0 && conflict_time_o == '0)))
    else $error("result fields not cleared for its kind");

endmodule

bind path_pair_conflict_detector_core pcd_checker #(
  .LOCATION_BITS(LOCATION_BITS)
) u_pcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .opcode_i        (opcode_i),
  .done_o          (done_o),
  .conflict_kind_o (conflict_kind_o),
  .agent_first_o   (agent_first_o),
  .agent_second_o  (agent_second_o),
  .place_first_o   (place_first_o),
  .place_second_o  (place_second_o),
  .conflict_time_o (conflict_time_o)
);

/* tb/pcd_conflict_checker.sv */
// Checker for the path pair conflict detector: mirrors the path stores and
// registers, predicts the result of every check and compares each result.
// Depends on pcd_pkg.
`timescale 1ns / 1ps

module pcd_conflict_checker #(
  parameter int MAX_STEPS     = 256,
  parameter int LOCATION_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           busy,
  input  logic [pcd_pkg::OP_W-1:0]       opcode_i,
  input  logic [pcd_pkg::STEP_W-1:0]     step_index_i,
  input  logic [LOCATION_BITS-1:0]       cell_location_i,
  input  logic [pcd_pkg::STEP_W-1:0]     first_time_i,
  input  logic [pcd_pkg::LEN_W-1:0]      length_a_i,
  input  logic [pcd_pkg::LEN_W-1:0]      length_b_i,
  input  logic [pcd_pkg::AGENT_W-1:0]    agent_a_i,
  input  logic [pcd_pkg::AGENT_W-1:0]    agent_b_i,
  input  logic                           cfg_we_i,
  input  logic [pcd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           done_o,
  input  logic [pcd_pkg::KIND_W-1:0]     conflict_kind_o,
  input  logic [pcd_pkg::AGENT_W-1:0]    agent_first_o,
  input  logic [pcd_pkg::AGENT_W-1:0]    agent_second_o,
  input  logic [LOCATION_BITS-1:0]       place_first_o,
  input  logic [LOCATION_BITS-1:0]       place_second_o,
  input  logic [pcd_pkg::LEN_W-1:0]      conflict_time_o,
  output int unsigned                    error_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    results_o,
  output int unsigned                    conflicts_o
);
  import pcd_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [AGENT_W-1:0]       agent_first;
    logic [AGENT_W-1:0]       agent_second;
    logic [LOCATION_BITS-1:0] place_first;
    logic [LOCATION_BITS-1:0] place_second;
    logic [LEN_W-1:0]         ctime;
  } conflict_t;

  logic [LOCATION_BITS-1:0] route_a [MAX_STEPS];
  logic [LOCATION_BITS-1:0] route_b [MAX_STEPS];
  logic                     hold_mode;
  logic [WIN_W-1:0]         window_last;
  logic [ROB_W-1:0]         margin;
  conflict_t                expected_q [$];

  function automatic conflict_t make_conflict(input logic [KIND_W-1:0] kind,
                                              input logic [AGENT_W-1:0] ag1,
                                              input logic [AGENT_W-1:0] ag2,
                                              input logic [LOCATION_BITS-1:0] p1,
                                              input logic [LOCATION_BITS-1:0] p2,
                                              input int t);
    conflict_t r;
    r.kind         = kind;
    r.agent_first  = ag1;
    r.agent_second = ag2;
    r.place_first  = p1;
    r.place_second = p2;
    r.ctime        = t[LEN_W-1:0];
    return r;
  endfunction

  function automatic conflict_t predict_conflict(input int start_t, input int len_a,
                                                 input int len_b,
                                                 input logic [AGENT_W-1:0] ag_a,
                                                 input logic [AGENT_W-1:0] ag_b);
    conflict_t                r;
    int                       shorter, longer, t, i, w, k, s1, s2, lo, hi;
    bit                       a_short;
    logic [LOCATION_BITS-1:0] l1, l2, park;
    r = '0;
    if (len_a > MAX_STEPS) len_a = MAX_STEPS;
    if (len_b > MAX_STEPS) len_b = MAX_STEPS;
    if (len_a == 0 || len_b == 0) return r;
    if (hold_mode) begin
      shorter = (len_a < len_b) ? len_a : len_b;
      for (t = start_t; t < shorter; t++) begin
        l1 = route_a[t];
        l2 = route_b[t];
        if (l1 == l2) return make_conflict(KIND_VERTEX, ag_a, ag_b, l1, '0, t);
        if (t < shorter - 1 && l1 == route_b[t+1] && l2 == route_a[t+1])
          return make_conflict(KIND_EDGE, ag_a, ag_b, l1, l2, t + 1);
      end
      if (len_a != len_b) begin
        a_short = len_a < len_b;
        park    = a_short ? route_a[shorter-1] : route_b[shorter-1];
        longer  = a_short ? len_b : len_a;
        for (t = shorter; t < longer; t++) begin
          if ((a_short ? route_b[t] : route_a[t]) == park)
            return make_conflict(KIND_VERTEX, a_short ? ag_a : ag_b, a_short ? ag_b : ag_a,
                                 park, '0, t);
        end
      end
    end else begin
      w  = int'(window_last) + 1;
      k  = int'(margin);
      s1 = (len_a < w) ? len_a : w;
      s2 = (len_b < w) ? len_b : w;
      for (t = start_t; t < s1; t++) begin
        if (s2 <= t - k) return r;
        if (k > 0) begin
          lo = (t - k < 0) ? 0 : t - k;
          hi = (t + k < s2 - 1) ? t + k : s2 - 1;
          for (i = lo; i <= hi; i++) begin
            if (route_b[i] == route_a[t])
              return make_conflict(KIND_VERTEX, ag_a, ag_b, route_a[t], '0, (i < t) ? i : t);
          end
        end else begin
          l1 = route_a[t];
          l2 = route_b[t];
          if (l1 == l2) return make_conflict(KIND_VERTEX, ag_a, ag_b, l1, '0, t);
          if (t < s1 - 1 && t < s2 - 1 && l1 == route_b[t+1] && l2 == route_a[t+1])
            return make_conflict(KIND_EDGE, ag_a, ag_b, l1, l2, t + 1);
        end
      end
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    conflict_t want;
    conflict_t predicted;
    if (!rst_ni) begin
      hold_mode     = 1'b0;
      window_last   = '1;
      margin        = '0;
      expected_q.delete();
      error_count_o = 0;
      pending_o     = 0;
      results_o     = 0;
      conflicts_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_HOLD:   hold_mode   = cfg_data_i[0];
          CFG_WINDOW: window_last = cfg_data_i[WIN_W-1:0];
          CFG_ROBUST: margin      = cfg_data_i[ROB_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (opcode_i)
          OP_LOAD_A: route_a[step_index_i] = cell_location_i;
          OP_LOAD_B: route_b[step_index_i] = cell_location_i;
          OP_CHECK: begin
            predicted  = predict_conflict(int'(first_time_i),
                                          int'(length_a_i), int'(length_b_i),
                                          agent_a_i, agent_b_i);
            expected_q = {expected_q, predicted};
          end
          default: ;
        endcase
      end
      if (done_o === 1'b1) begin
        results_o++;
        if (conflict_kind_o != KIND_NONE) conflicts_o++;
        if (expected_q.size() == 0) begin
          $display("%0t ns: result transfer with no check outstanding", $time);
          error_count_o++;
        end else begin
          want = expected_q.pop_front();
          compare_field("conflict_kind", 32'(want.kind), 32'(conflict_kind_o));
          compare_field("agent_first", 32'(want.agent_first), 32'(agent_first_o));
          compare_field("agent_second", 32'(want.agent_second), 32'(agent_second_o));
          compare_field("place_first", 32'(want.place_first), 32'(place_first_o));
          compare_field("place_second", 32'(want.place_second), 32'(place_second_o));
          compare_field("conflict_time", 32'(want.ctime), 32'(conflict_time_o));
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/tb_path_pair_conflict_detector_core.sv */
// Testbench top for the path pair conflict detector: directed and random path
// loads and checks under several register settings and pacing phases.
// Depends on pcd_pkg, path_pair_conflict_detector_core and pcd_conflict_checker.
`timescale 1ns / 1ps

module tb_path_pair_conflict_detector_core;
  import pcd_pkg::*;

  localparam int MAX_STEPS       = 256;
  localparam int LOCATION_BITS   = 20;
  localparam int LEN_MAX         = (1 << LEN_W) - 1;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int WATCHDOG_LIMIT  = 40000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int SETTLE_CYCLES   = 4;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     start           = 1'b0;
  logic                     busy;
  logic [OP_W-1:0]          opcode_i        = '0;
  logic [STEP_W-1:0]        step_index_i    = '0;
  logic [LOCATION_BITS-1:0] cell_location_i = '0;
  logic [STEP_W-1:0]        first_time_i    = '0;
  logic [LEN_W-1:0]         length_a_i      = '0;
  logic [LEN_W-1:0]         length_b_i      = '0;
  logic [AGENT_W-1:0]       agent_a_i       = '0;
  logic [AGENT_W-1:0]       agent_b_i       = '0;
  logic                     cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i      = '0;
  logic                     done_o;
  logic [KIND_W-1:0]        conflict_kind_o;
  logic [AGENT_W-1:0]       agent_first_o;
  logic [AGENT_W-1:0]       agent_second_o;
  logic [LOCATION_BITS-1:0] place_first_o;
  logic [LOCATION_BITS-1:0] place_second_o;
  logic [LEN_W-1:0]         conflict_time_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned conflicts;

  bit          a_written [MAX_STEPS];
  bit          b_written [MAX_STEPS];
  int          sender_idle;
  int          item_count;
  int          check_count;
  int          setting_count;
  int unsigned quiet_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  path_pair_conflict_detector_core #(
    .MAX_STEPS     (MAX_STEPS),
    .LOCATION_BITS (LOCATION_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .step_index_i    (step_index_i),
    .cell_location_i (cell_location_i),
    .first_time_i    (first_time_i),
    .length_a_i      (length_a_i),
    .length_b_i      (length_b_i),
    .agent_a_i       (agent_a_i),
    .agent_b_i       (agent_b_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .conflict_kind_o (conflict_kind_o),
    .agent_first_o   (agent_first_o),
    .agent_second_o  (agent_second_o),
    .place_first_o   (place_first_o),
    .place_second_o  (place_second_o),
    .conflict_time_o (conflict_time_o)
  );

  pcd_conflict_checker #(
    .MAX_STEPS     (MAX_STEPS),
    .LOCATION_BITS (LOCATION_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .step_index_i    (step_index_i),
    .cell_location_i (cell_location_i),
    .first_time_i    (first_time_i),
    .length_a_i      (length_a_i),
    .length_b_i      (length_b_i),
    .agent_a_i       (agent_a_i),
    .agent_b_i       (agent_b_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .conflict_kind_o (conflict_kind_o),
    .agent_first_o   (agent_first_o),
    .agent_second_o  (agent_second_o),
    .place_first_o   (place_first_o),
    .place_second_o  (place_second_o),
    .conflict_time_o (conflict_time_o),
    .error_count_o   (mismatches),
    .pending_o       (pending),
    .results_o       (results),
    .conflicts_o     (conflicts)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o === 1'b1 || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  task automatic drive_item(input logic [OP_W-1:0] op, input logic [STEP_W-1:0] idx,
                            input logic [LOCATION_BITS-1:0] site,
                            input logic [STEP_W-1:0] first,
                            input logic [LEN_W-1:0] la, input logic [LEN_W-1:0] lb,
                            input logic [AGENT_W-1:0] ag_a, input logic [AGENT_W-1:0] ag_b);
    while ($urandom_range(99) < sender_idle) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    opcode_i        = op;
    step_index_i    = idx;
    cell_location_i = site;
    first_time_i    = first;
    length_a_i      = la;
    length_b_i      = lb;
    agent_a_i       = ag_a;
    agent_b_i       = ag_b;
    start           = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if (op != OP_UNUSED) item_count++;
  endtask

  task automatic load_step(input logic [OP_W-1:0] op, input int idx,
                           input logic [LOCATION_BITS-1:0] site);
    drive_item(op, STEP_W'(idx), site, STEP_W'($urandom), LEN_W'($urandom),
               LEN_W'($urandom), AGENT_W'($urandom), AGENT_W'($urandom));
    if (op == OP_LOAD_A) a_written[idx] = 1'b1;
    else b_written[idx] = 1'b1;
  endtask

  task automatic run_check(input int first, input int la, input int lb,
                           input logic [AGENT_W-1:0] ag_a, input logic [AGENT_W-1:0] ag_b);
    drive_item(OP_CHECK, STEP_W'($urandom), LOCATION_BITS'($urandom), STEP_W'(first),
               LEN_W'(la), LEN_W'(lb), ag_a, ag_b);
    check_count++;
  endtask

  // Register writes wait until the block has drained every outstanding check.
  task automatic write_setting(input logic hold, input logic [WIN_W-1:0] window,
                               input logic [ROB_W-1:0] robust);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = CFG_HOLD;
    cfg_data_i  = CFG_DATA_W'($urandom);
    cfg_data_i[0] = hold;
    @(negedge clk_i);
    cfg_index_i = CFG_WINDOW;
    cfg_data_i  = window;
    @(negedge clk_i);
    cfg_index_i = CFG_ROBUST;
    cfg_data_i  = CFG_DATA_W'($urandom);
    cfg_data_i[ROB_W-1:0] = robust;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    setting_count++;
  endtask

  task automatic next_setting(input int which);
    case (which % 7)
      0: write_setting(1'b0, 8'd255, 4'd0);
      1: write_setting(1'b1, WIN_W'($urandom), ROB_W'($urandom));
      2: write_setting(1'b0, 8'd0, 4'd0);
      3: write_setting(1'b0, 8'd255, 4'd15);
      4: write_setting(1'b0, WIN_W'($urandom), ROB_W'($urandom_range(1, 14)));
      5: write_setting(1'b0, WIN_W'($urandom_range(1, 20)), 4'd0);
      default: write_setting(1'b1, 8'd0, 4'd15);
    endcase
  endtask

  function automatic int prefix_len(input bit sel_b);
    int n;
    n = 0;
    while (n < MAX_STEPS && (sel_b ? b_written[n] : a_written[n])) n++;
    return n;
  endfunction

  // A spread of zero draws most locations from the all-zero and all-ones cells
  // and the rest at random; otherwise most come from a small set so that paths meet often.
  function automatic logic [LOCATION_BITS-1:0] pick_cell(input int spread);
    int roll;
    roll = $urandom_range(99);
    if (spread > 0 && roll < 75) return LOCATION_BITS'($urandom_range(0, spread));
    if (roll < 85) return ($urandom_range(1) == 0) ? '0 : '1;
    return LOCATION_BITS'($urandom);
  endfunction

  task automatic run_scenario(input int fixed_len);
    logic [LOCATION_BITS-1:0] cells_a [MAX_STEPS];
    logic [LOCATION_BITS-1:0] cells_b [MAX_STEPS];
    int len_a, len_b, spread, ia, ib, i, pa, pb, la, lb, first, longest, roll;
    if (fixed_len > 0) begin
      len_a = fixed_len;
      len_b = fixed_len;
    end else begin
      len_a = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      if ($urandom_range(3) == 0) len_b = len_a;
      else len_b = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
    end
    spread = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
    for (i = 0; i < len_a; i++) cells_a[i] = pick_cell(spread);
    i = 0;
    while (i < len_b) begin
      roll = $urandom_range(99);
      if (roll < 20 && i < len_a) begin
        cells_b[i] = cells_a[i];
        i++;
      end else if (roll < 40 && i + 1 < len_a && i + 1 < len_b) begin
        cells_b[i]   = cells_a[i+1];
        cells_b[i+1] = cells_a[i];
        i += 2;
      end else begin
        cells_b[i] = pick_cell(spread);
        i++;
      end
    end
    ia = 0;
    ib = 0;
    while (ia < len_a || ib < len_b) begin
      if (ib >= len_b || (ia < len_a && $urandom_range(1) == 0)) begin
        load_step(OP_LOAD_A, ia, cells_a[ia]);
        ia++;
      end else begin
        load_step(OP_LOAD_B, ib, cells_b[ib]);
        ib++;
      end
      roll = $urandom_range(199);
      if (roll < 6) begin
        load_step(roll[0] ? OP_LOAD_B : OP_LOAD_A, $urandom_range(0, MAX_STEPS - 1),
                  pick_cell(spread));
      end else if (roll < 9) begin
        drive_item(OP_UNUSED, STEP_W'($urandom), LOCATION_BITS'($urandom),
                   STEP_W'($urandom), LEN_W'($urandom), LEN_W'($urandom),
                   AGENT_W'($urandom), AGENT_W'($urandom));
      end
    end
    repeat ($urandom_range(1, 3)) begin
      pa   = prefix_len(1'b0);
      pb   = prefix_len(1'b1);
      roll = $urandom_range(99);
      if (roll < 55) begin
        la = len_a;
        lb = len_b;
      end else if (roll < 70) begin
        la = $urandom_range(0, pa);
        lb = $urandom_range(0, pb);
      end else if (roll < 78) begin
        la = roll[0] ? 0 : len_a;
        lb = roll[0] ? len_b : 0;
      end else if (roll < 86 && pa == MAX_STEPS && pb == MAX_STEPS) begin
        la = $urandom_range(MAX_STEPS, LEN_MAX);
        lb = $urandom_range(1, LEN_MAX);
      end else begin
        la = $urandom_range(1, len_a);
        lb = $urandom_range(1, len_b);
      end
      longest = (la > lb) ? la : lb;
      if (longest > 255) longest = 255;
      roll = $urandom_range(99);
      if (roll < 50) first = 0;
      else if (roll < 80) first = $urandom_range(0, longest);
      else first = $urandom_range(0, 255);
      run_check(first, la, lb, AGENT_W'($urandom), AGENT_W'($urandom));
    end
  endtask

  initial begin
    int phase, phase_base, base_idle, scenario;
    sender_idle   = 0;
    item_count    = 0;
    check_count   = 0;
    setting_count = 0;
    scenario      = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset register values first.
    run_check(0, 0, 5, '0, '1);
    run_check(7, 3, 0, '1, '0);
    load_step(OP_LOAD_A, 0, '0);
    load_step(OP_LOAD_A, 1, '1);
    load_step(OP_LOAD_A, 2, 20'd5);
    load_step(OP_LOAD_B, 0, '1);
    load_step(OP_LOAD_B, 1, '0);
    load_step(OP_LOAD_B, 2, 20'd7);
    run_check(0, 3, 3, '0, '1);
    run_check(1, 3, 3, '1, '0);
    run_check(200, 3, 3, 10'd3, 10'd9);
    drive_item(OP_UNUSED, '1, '1, '1, '1, '1, '1, '1);
    write_setting(1'b1, 8'd255, 4'd0);
    load_step(OP_LOAD_B, 3, 20'd5);
    load_step(OP_LOAD_B, 4, 20'd9);
    load_step(OP_LOAD_A, 3, 20'd1);
    load_step(OP_LOAD_A, 4, 20'd7);
    run_check(3, 3, 5, 10'd11, 10'd22);
    run_check(3, 5, 3, 10'd11, 10'd22);
    run_check(0, 5, 5, '0, '1);
    write_setting(1'b0, 8'd255, 4'd15);
    run_check(0, 5, 5, '1, '0);
    write_setting(1'b0, 8'd0, 4'd0);
    run_check(0, 5, 5, '0, '1);

    for (phase = 0; phase < 3; phase++) begin
      base_idle   = (phase == 0) ? 15 : (phase == 1) ? 62 : 0;
      sender_idle = base_idle;
      phase_base  = item_count;
      // One full-length pair early on makes every length legal afterwards.
      if (phase == 0) run_scenario(MAX_STEPS);
      while (item_count - phase_base < ITEMS_PER_PHASE) begin
        if (scenario % 6 == 0) next_setting(scenario / 6);
        run_scenario(0);
        scenario++;
      end
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Run covered %0d load and check transfers (%0d checks) over %0d register settings.",
             item_count, check_count, setting_count);
    $display("%0d results were compared, %0d of them reporting a conflict.",
             results, conflicts);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/pcd_pkg.sv
rtl/core/path_pair_conflict_detector_core.sv
rtl/core/pcd_checker.sv
tb/pcd_conflict_checker.sv
tb/tb_path_pair_conflict_detector_core.sv
